// ===== rtl/core/multi_queue_shared_buffer_macros.svh =====
// ----------------------------------------------------------------------------
// Multi-queue shared buffer: assertion macros
// Assertion wrappers; they expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_SHARED_BUFFER_MACROS_SVH
`define MULTI_QUEUE_SHARED_BUFFER_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, disabled while reset is asserted
`define MQSB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("mqsb assertion failed");

// Clocked property, checked during reset as well
`define MQSB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mqsb assertion failed");

`else

`define MQSB_ASSERT(lbl, clk, rstn, prop)
`define MQSB_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== rtl/core/mqsb_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-queue shared buffer: package
// Word types, command and status codes, controller states and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package mqsb_pkg;

  localparam int DATA_W = 32;

  // Command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // Data returned by a dequeue that finds nothing (-1)
  localparam logic signed [DATA_W-1:0] DATA_NONE = '1;
  localparam logic signed [DATA_W-1:0] DATA_ZERO = '0;

  typedef struct packed {
    logic                     command;
    logic [1:0]               queue_id;
    logic signed [DATA_W-1:0] data_in;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic [1:0]               status;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_ENQ2,
    S_DEQ2,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // latch the input word, read the queue table
    logic look;        // decide, first round of memory access
    logic enq_commit;  // finish an enqueue
    logic deq_commit;  // finish a dequeue
    logic out_load;    // move the result into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_enq;
    logic reject;      // full, empty or nonexistent queue
  } dp_stat_t;

endpackage

// ===== rtl/core/mqsb_chan_if.sv =====
// ----------------------------------------------------------------------------
// Multi-queue shared buffer: valid/ready channel
// One word moves at a clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface mqsb_chan_if #(
  parameter type payload_t = mqsb_pkg::in_word_t
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/mqsb_ram.sv =====
// ----------------------------------------------------------------------------
// Multi-queue shared buffer: generic RAM
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module mqsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/mqsb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Multi-queue shared buffer: controller
// Sequences one word through lookup, commit and result hand-off, and owns
// the valid flag of the output register.
// ----------------------------------------------------------------------------
`include "multi_queue_shared_buffer_macros.svh"

module mqsb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  mqsb_pkg::dp_stat_t  stat,
  output mqsb_pkg::ctrl_cmd_t cmd
);

  mqsb_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mqsb_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      mqsb_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = mqsb_pkg::S_LOOK;
        end
      end
      mqsb_pkg::S_LOOK: begin
        cmd.look = 1'b1;
        priority if (stat.reject) begin
          state_nxt = mqsb_pkg::S_DONE;
        end else if (stat.is_enq) begin
          state_nxt = mqsb_pkg::S_ENQ2;
        end else begin
          state_nxt = mqsb_pkg::S_DEQ2;
        end
      end
      mqsb_pkg::S_ENQ2: begin
        cmd.enq_commit = 1'b1;
        state_nxt      = mqsb_pkg::S_DONE;
      end
      mqsb_pkg::S_DEQ2: begin
        cmd.deq_commit = 1'b1;
        state_nxt      = mqsb_pkg::S_DONE;
      end
      mqsb_pkg::S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = mqsb_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mqsb_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  // Accepted word always goes to lookup next
  `MQSB_ASSERT(a_accept_to_look, clk, rst_n,
    (state_r == mqsb_pkg::S_IDLE && in_valid) |=> (state_r == mqsb_pkg::S_LOOK))

  // A commit state is always followed by S_DONE
  `MQSB_ASSERT(a_commit_to_done, clk, rst_n,
    (state_r == mqsb_pkg::S_ENQ2 || state_r == mqsb_pkg::S_DEQ2) |=>
      (state_r == mqsb_pkg::S_DONE))

  // A result hand-off raises valid and frees the controller
  `MQSB_ASSERT(a_load_sets_valid, clk, rst_n,
    (state_r == mqsb_pkg::S_DONE && out_free) |=>
      (out_valid_r && state_r == mqsb_pkg::S_IDLE))

  // Input is taken only while idle
  `MQSB_ASSERT(a_ready_idle, clk, rst_n,
    in_ready |-> (state_r == mqsb_pkg::S_IDLE))

endmodule

// ===== rtl/core/mqsb_dp.sv =====
// ----------------------------------------------------------------------------
// Multi-queue shared buffer: datapath
// Queue table (head/tail), link memory, slot data memory, free-list head,
// fill count of never-used slots, and the result/output registers.
// ----------------------------------------------------------------------------
module mqsb_dp #(
  parameter int NUM_SLOTS  = 16,
  parameter int NUM_QUEUES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mqsb_pkg::ctrl_cmd_t cmd,
  output mqsb_pkg::dp_stat_t  stat,
  input  mqsb_pkg::in_word_t  in_word,
  output mqsb_pkg::out_word_t out_word
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int PTR_W  = $clog2(NUM_SLOTS + 1);
  localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int QT_W   = 2 * SLOT_W;
  localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_SLOTS);

  // Latched input word
  logic                             cmd_r;
  logic [1:0]                       qid_r;
  logic signed [mqsb_pkg::DATA_W-1:0] din_r;

  // List state
  logic [PTR_W-1:0]      free_head_r, free_head_nxt;
  logic [PTR_W-1:0]      fill_cnt_r, fill_cnt_nxt;
  logic [NUM_QUEUES-1:0] qvalid_r, qvalid_nxt;
  logic [SLOT_W-1:0]     slot_r;
  logic                  fresh_r;

  // Result and output registers
  logic signed [mqsb_pkg::DATA_W-1:0] res_data_r, out_data_r;
  logic [1:0]                         res_status_r, out_status_r;

  // Memory ports
  logic                        qt_we, lk_we, sd_we;
  logic [QIDX_W-1:0]           qt_waddr, qt_raddr;
  logic [QT_W-1:0]             qt_wdata, qt_rdata;
  logic [SLOT_W-1:0]           lk_waddr, lk_raddr, sd_raddr;
  logic [PTR_W-1:0]            lk_wdata, lk_rdata;
  logic [mqsb_pkg::DATA_W-1:0] sd_rdata;
  logic                        lk_re, sd_re;

  // Lookup decode
  logic              q_ok, head_ok, free_ok, is_enq, reject;
  logic [QIDX_W-1:0] qidx;
  logic [SLOT_W-1:0] head_s, tail_s, sel_s;
  logic [PTR_W-1:0]  enq_next, deq_next;

  assign qidx    = QIDX_W'(qid_r);
  assign q_ok    = int'(qid_r) < NUM_QUEUES;
  assign head_ok = q_ok && qvalid_r[qidx];
  assign free_ok = free_head_r != NIL;
  assign is_enq  = cmd_r == mqsb_pkg::CMD_ENQ;
  assign reject  = is_enq ? (!q_ok || !free_ok) : !head_ok;
  assign head_s  = qt_rdata[QT_W-1:SLOT_W];
  assign tail_s  = qt_rdata[SLOT_W-1:0];
  assign sel_s   = is_enq ? free_head_r[SLOT_W-1:0] : head_s;

  // A never-used slot links to its successor
  assign enq_next = fresh_r ? (PTR_W'(slot_r) + PTR_W'(1)) : lk_rdata;
  assign deq_next = lk_rdata;

  assign stat.is_enq = is_enq;
  assign stat.reject = reject;

  // Memory port and list-state steering
  always_comb begin
    qt_we         = 1'b0;
    qt_waddr      = qidx;
    qt_wdata      = '0;
    qt_raddr      = QIDX_W'(in_word.queue_id);
    lk_we         = 1'b0;
    lk_waddr      = slot_r;
    lk_wdata      = NIL;
    lk_re         = 1'b0;
    lk_raddr      = sel_s;
    sd_we         = 1'b0;
    sd_re         = 1'b0;
    sd_raddr      = head_s;
    free_head_nxt = free_head_r;
    fill_cnt_nxt  = fill_cnt_r;
    qvalid_nxt    = qvalid_r;
    if (cmd.look && !reject) begin
      lk_re = 1'b1;
      if (is_enq) begin
        // Append the free slot after the tail, store the value
        sd_we    = 1'b1;
        qt_we    = 1'b1;
        qt_wdata = {(head_ok ? head_s : sel_s), sel_s};
        qvalid_nxt[qidx] = 1'b1;
        if (head_ok) begin
          lk_we    = 1'b1;
          lk_waddr = tail_s;
          lk_wdata = PTR_W'(sel_s);
        end
      end else begin
        sd_re = 1'b1;
      end
    end
    if (cmd.enq_commit) begin
      // Slot becomes the new tail; free list advances
      lk_we         = 1'b1;
      lk_waddr      = slot_r;
      lk_wdata      = NIL;
      free_head_nxt = enq_next;
      if (fresh_r) begin
        fill_cnt_nxt = fill_cnt_r + PTR_W'(1);
      end
    end
    if (cmd.deq_commit) begin
      // Unlink head, push the slot onto the free list
      qt_we         = 1'b1;
      qt_wdata      = {deq_next[SLOT_W-1:0], tail_s};
      lk_we         = 1'b1;
      lk_waddr      = slot_r;
      lk_wdata      = free_head_r;
      free_head_nxt = PTR_W'(slot_r);
      if (deq_next == NIL) begin
        qvalid_nxt[qidx] = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      fill_cnt_r  <= '0;
      qvalid_r    <= '0;
    end else begin
      free_head_r <= free_head_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      qvalid_r    <= qvalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r <= in_word.command;
      qid_r <= in_word.queue_id;
      din_r <= in_word.data_in;
    end
    if (cmd.look) begin
      slot_r  <= sel_s;
      fresh_r <= PTR_W'(sel_s) >= fill_cnt_r;
      if (is_enq) begin
        res_data_r   <= mqsb_pkg::DATA_ZERO;
        res_status_r <= reject ? mqsb_pkg::STATUS_FULL : mqsb_pkg::STATUS_OK;
      end else begin
        res_data_r   <= mqsb_pkg::DATA_NONE;
        res_status_r <= mqsb_pkg::STATUS_EMPTY;
      end
    end
    if (cmd.deq_commit) begin
      res_data_r   <= sd_rdata;
      res_status_r <= mqsb_pkg::STATUS_OK;
    end
    if (cmd.out_load) begin
      out_data_r   <= res_data_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_word.data_out = out_data_r;
  assign out_word.status   = out_status_r;

  // Queue table: {head, tail} per queue
  mqsb_ram #(
    .WIDTH (QT_W),
    .DEPTH (NUM_QUEUES)
  ) u_qtab (
    .clk     (clk),
    .wr_en   (qt_we),
    .wr_addr (qt_waddr),
    .wr_data (qt_wdata),
    .rd_en   (cmd.accept),
    .rd_addr (qt_raddr),
    .rd_data (qt_rdata)
  );

  // Next-slot links
  mqsb_ram #(
    .WIDTH (PTR_W),
    .DEPTH (NUM_SLOTS)
  ) u_link (
    .clk     (clk),
    .wr_en   (lk_we),
    .wr_addr (lk_waddr),
    .wr_data (lk_wdata),
    .rd_en   (lk_re),
    .rd_addr (lk_raddr),
    .rd_data (lk_rdata)
  );

  // Slot values
  mqsb_ram #(
    .WIDTH (mqsb_pkg::DATA_W),
    .DEPTH (NUM_SLOTS)
  ) u_data (
    .clk     (clk),
    .wr_en   (sd_we),
    .wr_addr (sel_s),
    .wr_data (din_r),
    .rd_en   (sd_re),
    .rd_addr (sd_raddr),
    .rd_data (sd_rdata)
  );

endmodule

// ===== rtl/core/multi_queue_shared_buffer.sv =====
// ----------------------------------------------------------------------------
// Multi-queue shared buffer: top level
// NUM_QUEUES FIFO queues kept as linked lists in one buffer of NUM_SLOTS
// slots, with a shared free list. Every input word yields one result word.
// ----------------------------------------------------------------------------
// One word is handled at a time. A successful enqueue or dequeue passes
// through accept, lookup, commit and hand-off, in that order; a rejected
// one (full buffer, empty or nonexistent queue) skips commit. The commit
// step is needed because of the single write port of the link memory,
// which an enqueue into a non-empty queue writes twice, and because of
// the registered reads of the queue table and link memory. A new word is
// accepted the cycle after the previous result has been loaded, even while
// that result still waits on out_ch. A held result stalls the next word in
// its hand-off cycle. No clearing pass after reset: never-used slots are
// tracked by a fill count.
// ----------------------------------------------------------------------------
module multi_queue_shared_buffer #(
  parameter int NUM_SLOTS  = 16,
  parameter int NUM_QUEUES = 4
) (
  input logic        clk,
  input logic        rst_n,
  mqsb_chan_if.sink   in_ch,
  mqsb_chan_if.source out_ch
);

  mqsb_pkg::ctrl_cmd_t cmd;
  mqsb_pkg::dp_stat_t  stat;
  mqsb_pkg::in_word_t  in_word;
  mqsb_pkg::out_word_t out_word;

  assign in_word        = in_ch.payload;
  assign out_ch.payload = out_word;

  // Sequencer
  mqsb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Lists, memories and result registers
  mqsb_dp #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_QUEUES (NUM_QUEUES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_word  (in_word),
    .out_word (out_word)
  );

endmodule
